/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Defining ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/ntid_pkg.sv */
package ntid_pkg;

	localparam int CharWidth = 8;
	localparam int WordWidth = 16;
	localparam int CountWidth = 8;
	localparam int KindWidth = 2;
	localparam int PhaseWidth = 3;

	localparam logic [PhaseWidth-1:0] PH_SKIP = 3'd0;
	localparam logic [PhaseWidth-1:0] PH_LEN  = 3'd1;
	localparam logic [PhaseWidth-1:0] PH_ADDR = 3'd2;
	localparam logic [PhaseWidth-1:0] PH_DATA = 3'd3;
	localparam logic [PhaseWidth-1:0] PH_CSUM = 3'd4;
	localparam logic [PhaseWidth-1:0] PH_DONE = 3'd5;

	localparam logic [KindWidth-1:0] KIND_DATA     = 2'd0;
	localparam logic [KindWidth-1:0] KIND_SUM_GOOD = 2'd1;
	localparam logic [KindWidth-1:0] KIND_SUM_BAD  = 2'd2;
	localparam logic [KindWidth-1:0] KIND_END      = 2'd3;

	localparam logic [CharWidth-1:0] CHAR_CLASS_MASK = 8'o160;
	localparam logic [CharWidth-1:0] CHAR_CLASS_HEX  = 8'o100;
	localparam logic [WordWidth-1:0] END_ADDRESS     = 16'o177777;
	localparam logic [CountWidth-1:0] LOADER_RESET   = 8'd65;

	typedef struct packed {
		logic [KindWidth-1:0] kind;
		logic [WordWidth-1:0] block_sum;
		logic [WordWidth-1:0] word_value;
		logic [WordWidth-1:0] word_address;
	} result_t;

endpackage

/* hdl/nibble_text_image_decoder_core.sv */
// Decodes a text-encoded memory image one character per clock cycle while the result buffer
// has room. Characters whose bits 6..4 are not 100 are dropped; the rest give nibbles that build
// length bytes and 16-bit words. After loader_words leading words are discarded, each block
// yields one item per data word (kind 0, with its address and the running end-around-carry
// sum) and one checksum item (kind 1 good, kind 2 bad); the start address 0177777 gives an
// end-of-image item (kind 3), after which all input is ignored until reset. A character is
// registered on entry and decoded once the result buffer has room; its result is written
// into the result buffer and offered on the master side from there. One character is
// accepted in every cycle unless a registered character waits on a full buffer; a two-entry
// result buffer lets the slave side keep taking characters while one result waits to be taken.
`include "assert_macros.svh"

module nibble_text_image_decoder_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         loader_words_we,
	input  logic [ntid_pkg::CountWidth-1:0] loader_words_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ntid_pkg::CharWidth-1:0] s_tdata,  // raw_char
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [47:0]                  m_tdata,  // word_address, word_value, block_sum
	output logic [ntid_pkg::KindWidth-1:0] m_tuser   // kind
);
	import ntid_pkg::*;

	logic [CountWidth-1:0] loader_words_q;

	logic                 valid_s1;
	logic [CharWidth-1:0] char_s1;

	logic [PhaseWidth-1:0] phase_q;
	logic [1:0]            nibble_count_q;
	logic [WordWidth-1:0]  word_shift_q;
	logic [CountWidth-1:0] skip_count_q;
	logic [CountWidth-1:0] words_left_q;
	logic [WordWidth-1:0]  next_address_q;
	logic [WordWidth-1:0]  running_sum_q;

	logic [PhaseWidth-1:0] phase_d;
	logic [1:0]            nibble_count_d;
	logic [WordWidth-1:0]  word_shift_d;
	logic [CountWidth-1:0] skip_count_d;
	logic [CountWidth-1:0] words_left_d;
	logic [WordWidth-1:0]  next_address_d;
	logic [WordWidth-1:0]  running_sum_d;
	logic                  res_valid;
	result_t               res;

	logic [PhaseWidth-1:0] ph;
	logic                  word_done;
	logic [WordWidth:0]    sum_raw;
	logic [WordWidth-1:0]  sum_eac;

	result_t    buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       s1_fire;
	logic       push;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loader_words_q <= LOADER_RESET;
		end else if (loader_words_we) begin
			loader_words_q <= loader_words_wdata;
		end
	end

	assign s1_fire  = valid_s1 && (cnt_q != 2'd2);
	assign s_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	assign word_shift_d = {word_shift_q[WordWidth-5:0], char_s1[3:0]};
	assign sum_raw = {1'b0, running_sum_q} + {1'b0, word_shift_d};
	assign sum_eac = sum_raw[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, sum_raw[WordWidth]};

	always_comb begin
		phase_d        = phase_q;
		nibble_count_d = nibble_count_q;
		skip_count_d   = skip_count_q;
		words_left_d   = words_left_q;
		next_address_d = next_address_q;
		running_sum_d  = running_sum_q;
		res_valid      = 1'b0;
		res            = '0;
		ph             = phase_q;
		word_done      = 1'b0;

		if (phase_q != PH_DONE && (char_s1 & CHAR_CLASS_MASK) == CHAR_CLASS_HEX) begin
			if (phase_q == PH_SKIP && skip_count_q >= loader_words_q) begin
				ph = PH_LEN;
			end
			phase_d   = ph;
			word_done = (ph == PH_LEN) ? (nibble_count_q == 2'd1) : (nibble_count_q == 2'd3);
			if (!word_done) begin
				nibble_count_d = nibble_count_q + 2'd1;
			end else begin
				nibble_count_d = 2'd0;
				unique case (ph)
					PH_SKIP: begin
						skip_count_d = skip_count_q + 8'd1;
						if (skip_count_d >= loader_words_q) begin
							phase_d = PH_LEN;
						end
					end
					PH_LEN: begin
						words_left_d = word_shift_d[CountWidth-1:0];
						phase_d      = PH_ADDR;
					end
					PH_ADDR: begin
						if (word_shift_d == END_ADDRESS) begin
							phase_d   = PH_DONE;
							res_valid = 1'b1;
							res.kind  = KIND_END;
						end else begin
							next_address_d = word_shift_d;
							running_sum_d  = '0;
							phase_d        = (words_left_q == '0) ? PH_CSUM : PH_DATA;
						end
					end
					PH_DATA: begin
						running_sum_d    = sum_eac;
						res_valid        = 1'b1;
						res.kind         = KIND_DATA;
						res.word_address = next_address_q;
						res.word_value   = word_shift_d;
						res.block_sum    = sum_eac;
						next_address_d   = next_address_q + 16'd1;
						words_left_d     = words_left_q - 8'd1;
						if (words_left_d == '0) begin
							phase_d = PH_CSUM;
						end
					end
					PH_CSUM: begin
						res_valid      = 1'b1;
						res.kind       = (word_shift_d == running_sum_q) ? KIND_SUM_GOOD
						                                                 : KIND_SUM_BAD;
						res.word_value = word_shift_d;
						res.block_sum  = running_sum_q;
						phase_d        = PH_LEN;
					end
					default: begin
						phase_d = PH_DONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SKIP;
			nibble_count_q <= '0;
			word_shift_q   <= '0;
			skip_count_q   <= '0;
			words_left_q   <= '0;
			next_address_q <= '0;
			running_sum_q  <= '0;
		end else if (s1_fire && phase_q != PH_DONE
		             && (char_s1 & CHAR_CLASS_MASK) == CHAR_CLASS_HEX) begin
			phase_q        <= phase_d;
			nibble_count_q <= nibble_count_d;
			word_shift_q   <= word_shift_d;
			skip_count_q   <= skip_count_d;
			words_left_q   <= words_left_d;
			next_address_q <= next_address_d;
			running_sum_q  <= running_sum_d;
		end
	end

	assign push = s1_fire && res_valid;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = buf_q[rd_ptr_q].kind;
	assign m_tdata  = {buf_q[rd_ptr_q].block_sum, buf_q[rd_ptr_q].word_value,
	                   buf_q[rd_ptr_q].word_address};

	`ASSERT_IMPLY(a_buf_bound, clk, arst_n, 1'b1, cnt_q != 2'd3, "result buffer overfilled")
	`ASSERT_IMPLY(a_no_push_full, clk, arst_n, cnt_q == 2'd2, !push, "push into full buffer")
	`ASSERT_NEXT(a_done_sticks, clk, arst_n, phase_q == PH_DONE, phase_q == PH_DONE,
		"decoder left the end-of-image phase")
	`ASSERT_NEXT(a_end_to_done, clk, arst_n, push && res.kind == KIND_END, phase_q == PH_DONE,
		"end-of-image item without entering the end phase")

endmodule

/* verif/tb_nibble_text_image_decoder_core.sv */
`timescale 1ns / 100ps

module tb_nibble_text_image_decoder_core;
	import ntid_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_ITEMS = 1150;

	typedef struct packed {
		logic [PhaseWidth-1:0] phase;
		logic [1:0] nib;
		logic [WordWidth-1:0] shift;
		logic [CountWidth-1:0] skipped;
		logic [CountWidth-1:0] left;
		logic [WordWidth-1:0] addr;
		logic [WordWidth-1:0] sum;
	} image_state_t;

	typedef struct packed {
		logic [CharWidth-1:0] ch;
		logic typed;
		result_t word;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic loader_words_we = 1'b0;
	logic [CountWidth-1:0] loader_words_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [CharWidth-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [KindWidth-1:0] m_tuser;

	image_state_t img;
	logic [CountWidth-1:0] loader_cfg;
	result_t pending_words[$];
	int mismatches = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit stall_request = 1'b0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;

	always #2 clk = ~clk;

	nibble_text_image_decoder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.loader_words_we(loader_words_we),
		.loader_words_wdata(loader_words_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Advances the decoder image by one character and reports whether an item results.
	function automatic bit decode_char(input logic [CharWidth-1:0] c, output result_t r);
		logic [16:0] acc;
		logic [WordWidth-1:0] w;
		bit complete;
		r = '0;
		if (img.phase == PH_DONE || (c & CHAR_CLASS_MASK) != CHAR_CLASS_HEX)
			return 1'b0;
		if (img.phase == PH_SKIP && img.skipped >= loader_cfg)
			img.phase = PH_LEN;
		img.shift = {img.shift[11:0], c[3:0]};
		complete = (img.phase == PH_LEN) ? (img.nib == 2'd1) : (img.nib == 2'd3);
		if (!complete) begin
			img.nib = img.nib + 2'd1;
			return 1'b0;
		end
		img.nib = 2'd0;
		w = img.shift;
		case (img.phase)
			PH_SKIP: begin
				img.skipped = img.skipped + 1'b1;
				if (img.skipped >= loader_cfg)
					img.phase = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				img.left = w[7:0];
				img.phase = PH_ADDR;
				return 1'b0;
			end
			PH_ADDR: begin
				if (w == END_ADDRESS) begin
					img.phase = PH_DONE;
					r.kind = KIND_END;
					return 1'b1;
				end
				img.addr = w;
				img.sum = '0;
				img.phase = (img.left == 0) ? PH_CSUM : PH_DATA;
				return 1'b0;
			end
			PH_DATA: begin
				acc = {1'b0, img.sum} + {1'b0, w};
				img.sum = acc[15:0] + 16'(acc[16]);
				r.kind = KIND_DATA;
				r.word_address = img.addr;
				r.word_value = w;
				r.block_sum = img.sum;
				img.addr = img.addr + 1'b1;
				img.left = img.left - 1'b1;
				if (img.left == 0)
					img.phase = PH_CSUM;
				return 1'b1;
			end
			PH_CSUM: begin
				r.kind = (w == img.sum) ? KIND_SUM_GOOD : KIND_SUM_BAD;
				r.word_value = w;
				r.block_sum = img.sum;
				img.phase = PH_LEN;
				return 1'b1;
			end
			default: begin
				img.phase = PH_DONE;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic bit ends_image(input logic [CharWidth-1:0] c);
		image_state_t saved;
		result_t r;
		bit hit;
		saved = img;
		hit = decode_char(c, r) && r.kind == KIND_END;
		img = saved;
		return hit;
	endfunction

	function automatic logic [CharWidth-1:0] noise_char();
		logic [CharWidth-1:0] c;
		do
			c = 8'($urandom);
		while ((c & CHAR_CLASS_MASK) == CHAR_CLASS_HEX);
		return c;
	endfunction

	function automatic logic [WordWidth-1:0] pick_data();
		case ($urandom_range(7))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic probe_row_t quiet(input logic [CharWidth-1:0] c);
		return '{ch: c, typed: 1'b0, word: '0};
	endfunction

	function automatic probe_row_t yields(input logic [CharWidth-1:0] c,
			input logic [KindWidth-1:0] k, input logic [WordWidth-1:0] a,
			input logic [WordWidth-1:0] v, input logic [WordWidth-1:0] s);
		result_t r;
		r.kind = k;
		r.word_address = a;
		r.word_value = v;
		r.block_sum = s;
		return '{ch: c, typed: 1'b1, word: r};
	endfunction

	task automatic send_char(input logic [CharWidth-1:0] c, input bit fixed = 1'b0,
			input result_t fixed_word = '0);
		result_t r;
		bit produced;
		while (tx_gaps && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do
			@(posedge clk);
		while (!s_tready);
		produced = decode_char(c, r);
		if (fixed)
			pending_words.push_back(fixed_word);
		else if (produced)
			pending_words.push_back(r);
		items_sent++;
	endtask

	// A nibble that would end the image by accident has its low bit flipped.
	task automatic send_nibble(input logic [3:0] n, input bit may_end = 1'b0);
		logic [CharWidth-1:0] c;
		if ($urandom_range(99) < 15)
			send_char(noise_char());
		c = {1'($urandom), 3'b100, n};
		if (!may_end && ends_image(c))
			c[0] = ~c[0];
		send_char(c);
	endtask

	// Fewer than four nibbles truncate the word; more append zero nibbles.
	task automatic send_word(input logic [WordWidth-1:0] w, input int count = 4,
			input bit may_end = 1'b0);
		for (int k = 0; k < count; k++)
			send_nibble(k < 4 ? w[15 - 4 * k -: 4] : 4'h0, may_end);
	endtask

	task automatic realign();
		while (!(img.phase == PH_LEN && img.nib == 0) && img.phase != PH_DONE)
			send_nibble(img.phase == PH_LEN ? 4'h0 : 4'($urandom));
	endtask

	task automatic send_block(input int len, input logic [WordWidth-1:0] start,
			input bit good, input bit faulty);
		int bad_word;
		int cut;
		logic [7:0] len_byte;
		logic [WordWidth-1:0] w;
		len_byte = 8'(len);
		bad_word = faulty ? $urandom_range(len + 2, 1) : -1;
		cut = $urandom_range(6, 1);
		if (cut >= 4)
			cut++;
		send_nibble(len_byte[7:4]);
		send_nibble(len_byte[3:0]);
		send_word(start, bad_word == 1 ? cut : 4);
		for (int i = 0; i < len; i++)
			send_word(pick_data(), bad_word == i + 2 ? cut : 4);
		w = good ? img.sum : 16'($urandom);
		send_word(w, bad_word == len + 2 ? cut : 4);
		if (faulty)
			realign();
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_loader(input logic [CountWidth-1:0] v);
		drain();
		loader_words_we <= 1'b1;
		loader_words_wdata <= v;
		@(posedge clk);
		loader_words_we <= 1'b0;
		loader_cfg = v;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("item with none expected: kind %0d, data %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					mismatches++;
				end
				if (m_tdata[15:0] !== want.word_address) begin
					$error("word_address: expected %h, got %h", want.word_address,
						m_tdata[15:0]);
					mismatches++;
				end
				if (m_tdata[31:16] !== want.word_value) begin
					$error("word_value: expected %h, got %h", want.word_value,
						m_tdata[31:16]);
					mismatches++;
				end
				if (m_tdata[47:32] !== want.block_sum) begin
					$error("block_sum: expected %h, got %h", want.block_sum, m_tdata[47:32]);
					mismatches++;
				end
			end
		end
		if (stall_request) begin
			stall_left = HOLD_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(rx_gaps && $urandom_range(99) < 29);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		probe_row_t probes[26];
		int blocks;
		int len;
		int budget;
		logic [WordWidth-1:0] start;
		img = '0;
		img.phase = PH_SKIP;
		loader_cfg = LOADER_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset count of loader words is raised to the maximum part way through a word and
		// then cut to zero once more words have gone, so the next nibble starts a block.
		repeat (64) send_word(16'($urandom));
		send_nibble(4'($urandom));
		send_nibble(4'($urandom));
		write_loader(8'hFF);
		send_nibble(4'($urandom));
		send_nibble(4'($urandom));
		repeat (7) send_word(16'($urandom));
		write_loader(8'h00);

		// One word at the top of memory with a bad checksum, then an empty block.
		probes = '{
			quiet(8'h00), quiet(8'h40), quiet(8'hC1),
			quiet(8'h4F), quiet(8'hCF), quiet(8'hFF), quiet(8'h4F), quiet(8'h4E),
			quiet(8'hCF), quiet(8'h4F), quiet(8'h4F),
			yields(8'hCF, KIND_DATA, 16'hFFFE, 16'hFFFF, 16'hFFFF),
			quiet(8'h40), quiet(8'hC0), quiet(8'h40),
			yields(8'h40, KIND_SUM_BAD, 16'h0000, 16'h0000, 16'hFFFF),
			quiet(8'h40), quiet(8'h40),
			quiet(8'h41), quiet(8'h42), quiet(8'h43), quiet(8'h44),
			quiet(8'h40), quiet(8'h40), quiet(8'h40),
			yields(8'hC0, KIND_SUM_GOOD, 16'h0000, 16'h0000, 16'h0000)
		};
		foreach (probes[i])
			send_char(probes[i].ch, probes[i].typed, probes[i].word);

		blocks = 0;
		while (items_sent < TARGET_ITEMS) begin
			budget = (TARGET_ITEMS - items_sent) / 5;
			if (blocks % 9 == 4)
				write_loader(blocks % 27 == 4 ? 8'hFF : 8'($urandom));
			tx_gaps = !(blocks >= 12 && blocks < 22);
			rx_gaps = tx_gaps;
			if (blocks == 6)
				stall_request = 1'b1;
			if (blocks == 6)
				len = 16;
			else if ($urandom_range(39) == 0)
				len = $urandom_range(budget > 255 ? 255 : budget);
			else
				len = $urandom_range(6);
			if ($urandom_range(3) == 0)
				start = 16'hFFFF - 16'($urandom_range(4, 1));
			else
				start = 16'($urandom);
			if (start == END_ADDRESS)
				start = 16'h0000;
			send_block(len, start, $urandom_range(99) < 60, $urandom_range(11) == 0);
			blocks++;
		end

		realign();
		send_nibble(4'($urandom));
		send_nibble(4'($urandom));
		send_word(END_ADDRESS, 4, 1'b1);
		repeat (40) send_char(8'($urandom));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/ntid_pkg.sv
hdl/nibble_text_image_decoder_core.sv
verif/tb_nibble_text_image_decoder_core.sv
